@@ design/srm_pkg.sv @@
package srm_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int PAT_BYTES   = 32;
  localparam int LEN_MAX     = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;
  localparam int NTOK        = LEN_MAX;
  localparam int NCELL       = NTOK + 1;
  localparam int TC_W        = $clog2(NTOK + 1);
  localparam int TOK_IDX_W   = (NTOK > 1) ? $clog2(NTOK) : 1;
  localparam int LEN_W       = 6;
  localparam int PAT_IDX_W   = 5;
  localparam int PAT_W       = PAT_BYTES * 8;
  localparam int DATA_W      = 64;
  localparam int ADDR_W      = 6;
  localparam int REG_IDX_W   = 3;
  localparam int NWORDS      = 4;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [REG_IDX_W-1:0] REG_PAT0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PAT1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PAT2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PAT3 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LEN  = 3'd4;

  typedef enum logic [2:0] {
    TK_LIT,
    TK_ANY,
    TK_STAR_LIT,
    TK_STAR_ANY,
    TK_END
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [7:0] chr;
  } tok_t;

  typedef struct packed {
    logic                 we;
    logic [TOK_IDX_W-1:0] idx;
    tok_t                 tok;
  } tok_wr_t;

  typedef struct packed {
    logic in_use;
    logic valid;
  } cell_ctrl_t;

  typedef struct packed {
    logic cstar;
    logic adv;
  } link_t;

  typedef struct packed {
    logic acc;
    logic fin;
  } hit_t;

  typedef enum logic {
    BLD_IDLE,
    BLD_RUN
  } bld_state_t;

endpackage

@@ design/simple_regex_matcher_core.sv @@
// Streaming tiny-regex matcher: literal bytes, '.', 'x*', leading '^' and trailing '$'.
// Text bytes enter one per cycle on in_* unless a tokenizer pass runs or a pending
// result is stalled; a zero byte closes the text and in the next cycle a single result
// (matched in bit 0) is offered on out_*. The automaton is a row of one cell per token
// plus an accept cell, all updated in the same cycle. Any write to a pattern or length
// register starts a tokenizer pass over the pattern bytes, taking 'x*' pairs together;
// in_tready is low during that pass. Registers sit at byte addresses 8*i, 64-bit data.
module simple_regex_matcher_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [7:0] text_char
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [7:0]                 out_tdata,  // [0] matched, [7:1] zero
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [srm_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [srm_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [srm_pkg::DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import srm_pkg::*;

  logic [DATA_W-1:0]    pat_r [NWORDS];
  logic [LEN_W-1:0]     len_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr, build_start;

  logic [PAT_W-1:0]     pattern;
  tok_wr_t              tok_wr;
  logic [TC_W-1:0]      tok_count;
  logic                 anchored, busy;

  link_t                link [NCELL+1];
  hit_t                 hits [NCELL];
  logic [NCELL-1:0]     acc_vec, fin_vec, active_vec;
  logic                 acc_any, fin_any;

  logic                 in_acc, step, rearm;
  logic                 match_seen_r, match_seen_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_match_r, out_match_nxt;

  assign cfg_pready  = 1'b1;
  assign reg_idx     = cfg_paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
  assign cfg_wr      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign build_start = cfg_wr && (reg_idx <= REG_LEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < NWORDS; w++) begin
        pat_r[w] <= '0;
      end
      len_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_PAT0: pat_r[0] <= cfg_pwdata;
        REG_PAT1: pat_r[1] <= cfg_pwdata;
        REG_PAT2: pat_r[2] <= cfg_pwdata;
        REG_PAT3: pat_r[3] <= cfg_pwdata;
        REG_LEN:  len_r    <= cfg_pwdata[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PAT0: cfg_prdata = pat_r[0];
      REG_PAT1: cfg_prdata = pat_r[1];
      REG_PAT2: cfg_prdata = pat_r[2];
      REG_PAT3: cfg_prdata = pat_r[3];
      REG_LEN:  cfg_prdata = DATA_W'(len_r);
      default:  cfg_prdata = '0;
    endcase
  end

  assign pattern = {pat_r[3], pat_r[2], pat_r[1], pat_r[0]};

  srm_tokenizer u_tok (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (build_start),
    .pattern   (pattern),
    .pat_len   (len_r),
    .tok_wr    (tok_wr),
    .tok_count (tok_count),
    .anchored  (anchored),
    .busy      (busy)
  );

  assign in_tready = !busy && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid & in_tready;
  assign step      = in_acc && (in_tdata != CH_NUL);
  assign rearm     = in_acc && (in_tdata == CH_NUL);

  assign link[0].cstar = 1'b0;
  assign link[0].adv   = ~anchored;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    cell_ctrl_t ctrl;
    logic       wr_en;
    assign ctrl.in_use = (tok_count > TC_W'(k));
    assign ctrl.valid  = (tok_count >= TC_W'(k));
    assign wr_en       = tok_wr.we && (k < NTOK) &&
                         (tok_wr.idx == TOK_IDX_W'(k));
    srm_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .start_cell (k == 0),
      .wr_en      (wr_en),
      .wr_tok     (tok_wr.tok),
      .ctrl       (ctrl),
      .step       (step),
      .rearm      (rearm),
      .ch         (in_tdata),
      .link_in    (link[k]),
      .link_out   (link[k+1]),
      .hit        (hits[k]),
      .active     (active_vec[k])
    );
    assign acc_vec[k] = hits[k].acc;
    assign fin_vec[k] = hits[k].fin;
  end

  assign acc_any = |acc_vec;
  assign fin_any = |fin_vec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_seen_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      match_seen_r <= match_seen_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_match_r <= out_match_nxt;
  end

  always_comb begin
    match_seen_nxt = match_seen_r;
    out_valid_nxt  = out_valid_r;
    out_match_nxt  = out_match_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (rearm) begin
      match_seen_nxt = 1'b0;
      out_valid_nxt  = 1'b1;
      out_match_nxt  = match_seen_r | acc_any | fin_any;
    end else if (step) begin
      match_seen_nxt = match_seen_r | acc_any;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_match_r};

  a_rearm_start : assert property (@(posedge clk) disable iff (!rst_n)
    rearm |=> (active_vec == NCELL'(1)))
    else $error("automaton not re-armed after end of text");

  a_result_src : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(rearm))
    else $error("result raised without a closing zero byte");

  a_single_end : assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> ($countones(fin_vec) <= 1))
    else $error("more than one end anchor token live");

endmodule

@@ design/srm_tokenizer.sv @@
module srm_tokenizer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [srm_pkg::PAT_W-1:0]    pattern,
  input  logic [srm_pkg::LEN_W-1:0]    pat_len,
  output srm_pkg::tok_wr_t             tok_wr,
  output logic [srm_pkg::TC_W-1:0]     tok_count,
  output logic                         anchored,
  output logic                         busy
);
  import srm_pkg::*;

  bld_state_t       state_r, state_nxt;
  logic [LEN_W-1:0] i_r, i_nxt;
  logic [TC_W-1:0]  k_r, k_nxt;
  logic [TC_W-1:0]  tc_r, tc_nxt;
  logic             anch_r, anch_nxt;

  logic [LEN_W-1:0]     len_c;
  logic [LEN_W-1:0]     i_p1;
  logic [PAT_IDX_W-1:0] idx0, idx1;
  logic [7:0]           b0, b1;
  logic                 next_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BLD_IDLE;
      i_r     <= '0;
      k_r     <= '0;
      tc_r    <= '0;
      anch_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      k_r     <= k_nxt;
      tc_r    <= tc_nxt;
      anch_r  <= anch_nxt;
    end
  end

  always_comb begin
    len_c     = (pat_len > LEN_W'(LEN_MAX)) ? LEN_W'(LEN_MAX) : pat_len;
    i_p1      = i_r + 1'b1;
    idx0      = i_r[PAT_IDX_W-1:0];
    idx1      = i_p1[PAT_IDX_W-1:0];
    b0        = pattern[{idx0, 3'b000} +: 8];
    b1        = pattern[{idx1, 3'b000} +: 8];
    next_in   = (i_p1 < len_c);
    state_nxt = state_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    tc_nxt    = tc_r;
    anch_nxt  = anch_r;
    tok_wr.we       = 1'b0;
    tok_wr.idx      = k_r[TOK_IDX_W-1:0];
    tok_wr.tok.kind = TK_LIT;
    tok_wr.tok.chr  = b0;
    case (state_r)
      BLD_IDLE: begin
      end
      BLD_RUN: begin
        if (i_r >= len_c || b0 == CH_NUL) begin
          state_nxt = BLD_IDLE;
          tc_nxt    = k_r;
        end else if (i_r == '0 && b0 == CH_CARET) begin
          anch_nxt = 1'b1;
          i_nxt    = i_p1;
        end else begin
          tok_wr.we = 1'b1;
          k_nxt     = k_r + 1'b1;
          if (next_in && b1 == CH_STAR) begin
            tok_wr.tok.kind = (b0 == CH_DOT) ? TK_STAR_ANY : TK_STAR_LIT;
            i_nxt           = i_r + LEN_W'(2);
          end else if (b0 == CH_DOLLAR && (!next_in || b1 == CH_NUL)) begin
            tok_wr.tok.kind = TK_END;
            i_nxt           = i_p1;
          end else begin
            tok_wr.tok.kind = (b0 == CH_DOT) ? TK_ANY : TK_LIT;
            i_nxt           = i_p1;
          end
        end
      end
      default: begin
        state_nxt = BLD_IDLE;
      end
    endcase
    if (start) begin
      state_nxt = BLD_RUN;
      i_nxt     = '0;
      k_nxt     = '0;
      anch_nxt  = 1'b0;
    end
  end

  assign tok_count = tc_r;
  assign anchored  = anch_r;
  assign busy      = (state_r == BLD_RUN);

endmodule

@@ design/srm_cell.sv @@
module srm_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start_cell,
  input  logic                wr_en,
  input  srm_pkg::tok_t       wr_tok,
  input  srm_pkg::cell_ctrl_t ctrl,
  input  logic                step,
  input  logic                rearm,
  input  logic [7:0]          ch,
  input  srm_pkg::link_t      link_in,
  output srm_pkg::link_t      link_out,
  output srm_pkg::hit_t       hit,
  output logic                active
);
  import srm_pkg::*;

  tok_t tok_r;
  logic s_r, s_nxt;
  logic c, ch_eq, stay, n;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tok_r <= wr_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= start_cell;
    end else begin
      s_r <= s_nxt;
    end
  end

  always_comb begin
    // closure over zero-length stars rides the cstar chain
    c     = (s_r & ctrl.valid) | link_in.cstar;
    ch_eq = (tok_r.chr == ch);
    link_out.cstar = c & ctrl.in_use &
                     (tok_r.kind == TK_STAR_LIT || tok_r.kind == TK_STAR_ANY);
    link_out.adv   = c & ctrl.in_use &
                     ((tok_r.kind == TK_LIT && ch_eq) || tok_r.kind == TK_ANY);
    stay  = c & ctrl.in_use &
            ((tok_r.kind == TK_STAR_LIT && ch_eq) || tok_r.kind == TK_STAR_ANY);
    n     = (link_in.adv | stay) & ctrl.valid;
    hit.acc = c & ctrl.valid & ~ctrl.in_use;
    hit.fin = c & ctrl.in_use & (tok_r.kind == TK_END);
    s_nxt = s_r;
    if (rearm) begin
      s_nxt = start_cell;
    end else if (step) begin
      s_nxt = n;
    end
  end

  assign active = s_r;

endmodule

@@ bench/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import srm_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int HOLD_CYCLES = 150;
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          in_tdata;   // [7:0] text_char
  logic                out_tvalid;
  logic                out_tready;
  logic [7:0]          out_tdata;  // [0] matched, [7:1] zero
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [ADDR_W-1:0]   cfg_paddr;
  logic [DATA_W-1:0]   cfg_pwdata;
  logic [DATA_W-1:0]   cfg_prdata;
  logic                cfg_pready;

  simple_regex_matcher_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // matcher shadow: pattern registers, token table, live positions
  logic [63:0]      pat_word [NWORDS];
  logic [LEN_W-1:0] pat_len;
  tok_kind_t        tk_kind [NTOK];
  logic [7:0]       tk_chr [NTOK];
  int               n_tok;
  bit               anchored;
  logic [NCELL-1:0] live;
  bit               hit;

  bit               verdict_q [$];
  logic [7:0]       pbuf [PAT_BYTES];
  int               errors = 0;
  int               chars_sent = 0;
  int               quiet_cycles = 0;
  bit               idle_on = 1'b1;
  bit               hold_req = 1'b0;

  function automatic logic [7:0] pat_byte(input int i);
    return pat_word[i / 8][(i % 8) * 8 +: 8];
  endfunction

  function automatic void retokenize();
    int len;
    int i;
    logic [7:0] b;
    len = (pat_len > LEN_MAX) ? LEN_MAX : int'(pat_len);
    for (i = 0; i < len; i++) begin
      if (pat_byte(i) == CH_NUL) begin
        len = i;
        break;
      end
    end
    anchored = (len > 0) && (pat_byte(0) == CH_CARET);
    i = anchored ? 1 : 0;
    n_tok = 0;
    while (i < len && n_tok < NTOK) begin
      b = pat_byte(i);
      tk_chr[n_tok] = b;
      if (i + 1 < len && pat_byte(i + 1) == CH_STAR) begin
        tk_kind[n_tok] = (b == CH_DOT) ? TK_STAR_ANY : TK_STAR_LIT;
        i += 2;
      end else if (b == CH_DOLLAR && i + 1 == len) begin
        tk_kind[n_tok] = TK_END;
        i += 1;
      end else begin
        tk_kind[n_tok] = (b == CH_DOT) ? TK_ANY : TK_LIT;
        i += 1;
      end
      n_tok++;
    end
  endfunction

  function automatic logic [NCELL-1:0] live_mask();
    logic [NCELL:0] m;
    m = ({{NCELL{1'b0}}, 1'b1} << (n_tok + 1)) - 1;
    return m[NCELL-1:0];
  endfunction

  // returns 1 when the byte closes the text; verdict in matched
  function automatic bit match_char(input logic [7:0] ch, output bit matched);
    logic [NCELL-1:0] c;
    logic [NCELL-1:0] nxt;
    logic [NCELL-1:0] m;
    int k;
    m = live_mask();
    c = live & m;
    for (k = 0; k < n_tok; k++)
      if (c[k] && (tk_kind[k] == TK_STAR_LIT || tk_kind[k] == TK_STAR_ANY)) c[k + 1] = 1'b1;
    if (c[n_tok]) hit = 1'b1;
    matched = 1'b0;
    if (ch == CH_NUL) begin
      if (n_tok > 0 && tk_kind[n_tok - 1] == TK_END && c[n_tok - 1]) hit = 1'b1;
      matched = hit;
      live = 1;
      hit = 1'b0;
      return 1'b1;
    end
    nxt = '0;
    for (k = 0; k < n_tok; k++) begin
      if (c[k]) begin
        case (tk_kind[k])
          TK_LIT:      if (tk_chr[k] == ch) nxt[k + 1] = 1'b1;
          TK_ANY:      nxt[k + 1] = 1'b1;
          TK_STAR_LIT: if (tk_chr[k] == ch) nxt[k] = 1'b1;
          TK_STAR_ANY: nxt[k] = 1'b1;
          default: ;
        endcase
      end
    end
    if (!anchored) nxt[0] = 1'b1;
    live = nxt & m;
    return 1'b0;
  endfunction

  function automatic logic [7:0] rand_text_char();
    int r;
    r = $urandom_range(0, 15);
    case (r)
      0, 1, 2, 3, 4, 5: return "a";
      6, 7, 8, 9:       return "b";
      10, 11:           return "c";
      12:               return ($urandom_range(0, 1) != 0) ? CH_STAR : CH_DOLLAR;
      default:          return 8'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic logic [7:0] rand_pat_char();
    int r;
    r = $urandom_range(0, 15);
    case (r)
      0, 1, 2:   return "a";
      3, 4:      return "b";
      5:         return "c";
      6, 7:      return CH_DOT;
      8, 9, 10:  return CH_STAR;
      11:        return CH_DOLLAR;
      12:        return CH_CARET;
      13:        return 8'($urandom_range(1, 255));
      default:   return "a";
    endcase
  endfunction

  function automatic void fill_pattern(input string p);
    int i;
    for (i = 0; i < PAT_BYTES; i++) pbuf[i] = (i < p.len()) ? p[i] : CH_NUL;
  endfunction

  task automatic send_char(input logic [7:0] ch);
    bit got;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    do @(posedge clk); while (in_tready !== 1'b1);
    chars_sent++;
    if (match_char(ch, got)) verdict_q.push_back(got);
    @(negedge clk);
  endtask

  task automatic send_text(input string t);
    int i;
    for (i = 0; i < t.len(); i++) send_char(t[i]);
    send_char(CH_NUL);
  endtask

  // drain all pending verdicts, then let in-flight bytes settle
  task automatic quiesce();
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    quiesce();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    case (idx)
      REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3: pat_word[idx[1:0]] = val;
      REG_LEN: pat_len = val[LEN_W-1:0];
      default: ;
    endcase
    retokenize();
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    // tokenizer pass holds off input
    do @(posedge clk); while (in_tready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic write_pattern(input int len);
    logic [63:0] w;
    int i;
    int j;
    for (i = 0; i < NWORDS; i++) begin
      for (j = 0; j < 8; j++) w[j * 8 +: 8] = pbuf[i * 8 + j];
      cfg_write(REG_PAT0 + 3'(i), w);
    end
    cfg_write(REG_LEN, 64'(len));
  endtask

  task automatic rand_pattern(input int max_len);
    int len;
    int i;
    len = $urandom_range(0, max_len);
    for (i = 0; i < PAT_BYTES; i++) pbuf[i] = 8'($urandom_range(0, 255));
    for (i = 0; i < len && i < PAT_BYTES; i++) pbuf[i] = rand_pat_char();
    if (len > 0 && $urandom_range(0, 3) == 0) pbuf[0] = CH_CARET;
    if (len > 0 && len <= PAT_BYTES && $urandom_range(0, 3) == 0) pbuf[len - 1] = CH_DOLLAR;
    if ($urandom_range(0, 9) == 0) pbuf[$urandom_range(0, PAT_BYTES - 1)] = CH_NUL;
    write_pattern(len);
  endtask

  // mostly a text built around one instance of the current tokens
  task automatic send_rand_text(input bit closed);
    int k;
    if ($urandom_range(0, 3) != 0) begin
      if ($urandom_range(0, 1) != 0) repeat ($urandom_range(1, 3)) send_char(rand_text_char());
      for (k = 0; k < n_tok; k++) begin
        case (tk_kind[k])
          TK_LIT:      send_char(tk_chr[k]);
          TK_ANY:      send_char(rand_text_char());
          TK_STAR_LIT: repeat ($urandom_range(0, 2)) send_char(tk_chr[k]);
          TK_STAR_ANY: repeat ($urandom_range(0, 2)) send_char(rand_text_char());
          default: ;
        endcase
      end
      if ($urandom_range(0, 1) != 0) repeat ($urandom_range(1, 3)) send_char(rand_text_char());
    end else begin
      repeat ($urandom_range(0, 10)) send_char(rand_text_char());
    end
    if (closed) send_char(CH_NUL);
  endtask

  task automatic test_empty_pattern();
    send_text("");
    send_text("q");
  endtask

  task automatic test_anchors_and_stars();
    fill_pattern("^a.b*c$");
    write_pattern(7);
    send_text("axc");
    fill_pattern("a$b");
    write_pattern(3);
    send_text("a$b");
    fill_pattern("$");
    write_pattern(1);
    send_text("");
    fill_pattern("*a");
    write_pattern(2);
    send_text("x*a");
  endtask

  task automatic test_pattern_limits();
    // pattern cut short by an embedded NUL, length beyond range
    fill_pattern("abXcd");
    pbuf[2] = CH_NUL;
    write_pattern(63);
    send_text("ab");
    // full 32-byte pattern, oversized length
    fill_pattern("a*a*a*a*a*a*a*a*a*a*a*a*a*a*a*bc");
    write_pattern(40);
    send_text("bc");
    cfg_write(REG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);
    // shrink the pattern in the middle of a text
    fill_pattern("abcd");
    write_pattern(4);
    send_char("a");
    send_char("b");
    send_char("c");
    cfg_write(REG_LEN, 64'd2);
    send_text("d");
  endtask

  task automatic test_byte_extremes();
    fill_pattern("^.$");
    write_pattern(3);
    send_char(8'hFF);
    send_char(CH_NUL);
    send_char(8'h80);
    send_char(8'h01);
    send_char(CH_NUL);
  endtask

  task automatic test_random_patterns();
    int ph;
    int stop_at;
    for (ph = 0; ph < 8; ph++) begin
      rand_pattern((ph == 3) ? 63 : ((ph == 6) ? 32 : 10));
      stop_at = chars_sent + 35;
      while (chars_sent < stop_at) send_rand_text(1'b1);
      // sometimes leave a text open across the next reprogramming
      if ($urandom_range(0, 2) == 0) send_rand_text(1'b0);
    end
  endtask

  task automatic test_backpressure();
    int i;
    fill_pattern("a*b");
    write_pattern(3);
    hold_req = 1'b1;
    for (i = 0; i < 15; i++) begin
      if (i % 2 != 0) begin
        send_text("ab");
      end else begin
        send_text("");
      end
    end
  endtask

  task automatic test_steady_stream();
    int stop_at;
    idle_on = 1'b0;
    rand_pattern(12);
    stop_at = chars_sent + 50;
    while (chars_sent < stop_at) send_rand_text(1'b1);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    for (int i = 0; i < NWORDS; i++) pat_word[i] = '0;
    pat_len = '0;
    retokenize();
    live = 1;
    hit  = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_pattern();
    test_anchors_and_stars();
    test_pattern_limits();
    test_byte_extremes();
    test_random_patterns();
    test_backpressure();
    test_steady_stream();

    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // result side ready: random stalls, one long hold on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_result
    bit want;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual matched=%0b", $time, out_tdata[0]);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (out_tdata[0] !== want) begin
          $display("%0t matched mismatch: expected %0b actual %0b", $time, want, out_tdata[0]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule

@@ simple_regex_matcher_core.f @@
design/srm_pkg.sv
design/srm_tokenizer.sv
design/srm_cell.sv
design/simple_regex_matcher_core.sv
bench/tb_top.sv
